FILE: sv/assert_macros.svh
// Assertion helpers for the RTL; anp_back includes them.
// Each macro expects the module to have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every rising edge outside of reset.
`define ANP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

// Checks that a condition never holds outside of reset.
`define ANP_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ANP_ASSERT(label, prop)
`define ANP_ASSERT_NEVER(label, cond)

`endif

`endif

FILE: sv/anp_pkg.sv
package anp_pkg;

  // Default widths of the running value and of the digit counter.
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Depths of the command queue and of the result queue.
  localparam int unsigned CMD_FIFO_DEPTH = 2;
  localparam int unsigned RES_FIFO_DEPTH = 2;

  // Character codes.
  localparam logic [7:0] CHAR_BS = 8'h08;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h66;

  // Value of the first hex letter digit.
  localparam logic [3:0] HEX_LETTER_BASE = 4'hA;

  // Decimal radix, used by the divider.
  localparam int unsigned RADIX_DEC = 10;

  // Result kind codes.
  localparam logic RES_ECHO  = 1'b0;
  localparam logic RES_VALUE = 1'b1;

  // Classified command passed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_DIGIT = 2'd0,
    CMD_BS    = 2'd1,
    CMD_CR    = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        hex;
    logic [3:0]  digit;
    logic [7:0]  ch;
  } cmd_t;

  localparam int unsigned CMD_W = $bits(cmd_t);

endpackage

FILE: sv/anp_fifo.sv
module anp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update, wrapping at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage entries carry payload only.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/anp_front.sv
module anp_front import anp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_hex_mode_i,
  input  logic       push_i,
  input  logic [7:0] rx_char_i,
  output logic       full_o,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_full_i
);

  logic hex_mode_q;
  logic is_cmd;

  // The mode register takes every write at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      hex_mode_q <= cfg_hex_mode_i;
    end
  end

  // Classify the character; non-command characters are dropped here.
  always_comb begin
    is_cmd      = 1'b0;
    cmd_o.kind  = CMD_DIGIT;
    cmd_o.hex   = hex_mode_q;
    cmd_o.digit = '0;
    cmd_o.ch    = rx_char_i;
    if (rx_char_i == CHAR_CR) begin
      cmd_o.kind = CMD_CR;
      is_cmd     = 1'b1;
    end else if (rx_char_i inside {[CHAR_0:CHAR_9]}) begin
      cmd_o.digit = 4'(rx_char_i - CHAR_0);
      is_cmd      = 1'b1;
    end else if (hex_mode_q && (rx_char_i inside {[CHAR_UA:CHAR_UF]})) begin
      cmd_o.digit = 4'(rx_char_i - CHAR_UA) + HEX_LETTER_BASE;
      is_cmd      = 1'b1;
    end else if (hex_mode_q && (rx_char_i inside {[CHAR_LA:CHAR_LF]})) begin
      cmd_o.digit = 4'(rx_char_i - CHAR_LA) + HEX_LETTER_BASE;
      is_cmd      = 1'b1;
    end else if (rx_char_i == CHAR_BS) begin
      cmd_o.kind = CMD_BS;
      is_cmd     = 1'b1;
    end
  end

  // A character is taken whenever the command queue has room.
  assign full_o      = cmd_full_i;
  assign cmd_valid_o = push_i && !cmd_full_i && is_cmd;

endmodule

FILE: sv/anp_div10.sv
module anp_div10 import anp_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic [VALUE_BITS-1:0] dividend_i,
  output logic [VALUE_BITS-1:0] quot_o
);

  // Scaled reciprocal of ten: ceil(2^(VALUE_BITS+3) / 10) fits in VALUE_BITS bits.
  // The rounding error stays below one tenth, so the quotient is exact for every dividend.
  localparam int unsigned SHIFT = VALUE_BITS + 3;
  localparam int unsigned SW    = SHIFT + 1;
  localparam logic [SW-1:0] SCALE      = {1'b1, {SHIFT{1'b0}}};
  localparam logic [SW-1:0] RECIP_FULL = (SCALE + SW'(RADIX_DEC - 1)) / SW'(RADIX_DEC);
  localparam logic [VALUE_BITS-1:0] RECIP = RECIP_FULL[VALUE_BITS-1:0];

  logic [2*VALUE_BITS-1:0] product;

  // Divide by ten as one constant multiply and a shift.
  assign product = {{VALUE_BITS{1'b0}}, dividend_i} * {{VALUE_BITS{1'b0}}, RECIP};
  assign quot_o  = {3'b000, product[2*VALUE_BITS-1:SHIFT]};

endmodule

FILE: sv/anp_back.sv
module anp_back import anp_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  output logic                  cmd_pop_o,
  output logic [VALUE_BITS-1:0] div_dividend_o,
  input  logic [VALUE_BITS-1:0] div_quot_i,
  output logic                  res_push_o,
  input  logic                  res_full_i,
  output logic                  res_kind_o,
  output logic [7:0]            res_echo_o,
  output logic [VALUE_BITS-1:0] res_value_o
);

`include "assert_macros.svh"

  logic [VALUE_BITS-1:0] accum_q, accum_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [VALUE_BITS-1:0] mul10_add;
  logic [VALUE_BITS-1:0] mul16_add;
  logic [COUNT_BITS-1:0] count_inc;
  logic [COUNT_BITS-1:0] count_dec;

  // Digit arithmetic: times ten as two shifts and an add, times sixteen as a shift.
  assign mul10_add = (accum_q << 3) + (accum_q << 1) + VALUE_BITS'(cmd_i.digit);
  assign mul16_add = {accum_q[VALUE_BITS-5:0], cmd_i.digit};
  assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
  assign count_dec = count_q - 1'b1;

  assign div_dividend_o = accum_q;

  // Command execution, one command per cycle; a command that makes a result waits while the result queue is full.
  always_comb begin
    accum_d     = accum_q;
    count_d     = count_q;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    res_kind_o  = RES_ECHO;
    res_echo_o  = cmd_i.ch;
    res_value_o = '0;
    if (cmd_valid_i) begin
      case (cmd_i.kind)
        CMD_DIGIT: begin
          if (!res_full_i) begin
            cmd_pop_o  = 1'b1;
            res_push_o = 1'b1;
            accum_d    = cmd_i.hex ? mul16_add : mul10_add;
            count_d    = count_inc;
          end
        end
        CMD_CR: begin
          if (!res_full_i) begin
            cmd_pop_o   = 1'b1;
            res_push_o  = 1'b1;
            res_kind_o  = RES_VALUE;
            res_echo_o  = '0;
            res_value_o = accum_q;
            accum_d     = '0;
            count_d     = '0;
          end
        end
        CMD_BS: begin
          if (count_q == '0) begin
            // Backspace on an empty entry is dropped without a result.
            cmd_pop_o = 1'b1;
          end else if (!res_full_i) begin
            cmd_pop_o  = 1'b1;
            res_push_o = 1'b1;
            accum_d    = cmd_i.hex ? (accum_q >> 4) : div_quot_i;
            count_d    = count_dec;
          end
        end
        default: begin
          cmd_pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      count_q <= '0;
    end else begin
      accum_q <= accum_d;
      count_q <= count_d;
    end
  end

  `ANP_ASSERT_NEVER(a_res_overflow, res_push_o && res_full_i)
  `ANP_ASSERT_NEVER(a_pop_empty, cmd_pop_o && !cmd_valid_i)
  `ANP_ASSERT(a_push_pops, res_push_o |-> cmd_pop_o)
  `ANP_ASSERT(a_echo_no_value, (res_push_o && res_kind_o == RES_ECHO) |-> (res_value_o == '0))
  `ANP_ASSERT(a_cr_clears, (cmd_pop_o && cmd_i.kind == CMD_CR) |=> (count_q == '0))

endmodule

FILE: sv/ascii_number_entry_parser.sv
// Channel   Direction  Handshake                    Payload
// input     in         push / full                  rx_char_i
// result    out        empty / pop                  result_kind_o, echo_char_o, value_o
// config    in         cfg_valid_i / cfg_ready_o    cfg_hex_mode_i
//
// A character is taken per cycle unless full; it reaches the results via both queues.
// Every command, a decimal backspace included, is executed as the back end pops it.
// Reset clears the mode, the running value and the digit count; no clearing pass.
// Two-entry command and result queues let either side stall without stopping the other.
// The input stalls only once the result queue is full and then the command queue fills.
module ascii_number_entry_parser import anp_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_hex_mode_i,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            rx_char_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  result_kind_o,
  output logic [7:0]            echo_char_o,
  output logic [VALUE_BITS-1:0] value_o
);

  localparam int unsigned RES_W = 1 + 8 + VALUE_BITS;

  logic                  cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t                  cmd_in, cmd_head;
  logic [VALUE_BITS-1:0] div_dividend, div_quot;
  logic                  res_push, res_full;
  logic                  res_kind;
  logic [7:0]            res_echo;
  logic [VALUE_BITS-1:0] res_value;
  logic [RES_W-1:0]      res_in, res_head;

  // Front end: mode register and character classification.
  anp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_hex_mode_i(cfg_hex_mode_i),
    .push_i        (push),
    .rx_char_i     (rx_char_i),
    .full_o        (full),
    .cmd_valid_o   (cmd_push),
    .cmd_o         (cmd_in),
    .cmd_full_i    (cmd_full)
  );

  // Command queue between the two halves.
  anp_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .data_o (cmd_head)
  );

  // Back end: running value, digit count and result generation.
  anp_back #(
    .VALUE_BITS(VALUE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!cmd_empty),
    .cmd_i         (cmd_head),
    .cmd_pop_o     (cmd_pop),
    .div_dividend_o(div_dividend),
    .div_quot_i    (div_quot),
    .res_push_o    (res_push),
    .res_full_i    (res_full),
    .res_kind_o    (res_kind),
    .res_echo_o    (res_echo),
    .res_value_o   (res_value)
  );

  // Combinational divide by ten for decimal backspace.
  anp_div10 #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div10 (
    .dividend_i(div_dividend),
    .quot_o    (div_quot)
  );

  // Result queue; its head drives the result ports.
  assign res_in = {res_kind, res_echo, res_value};

  anp_fifo #(
    .WIDTH(RES_W),
    .DEPTH(RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (res_head)
  );

  assign {result_kind_o, echo_char_o, value_o} = res_head;

endmodule

FILE: tb/number_entry_checker.sv
module number_entry_checker import anp_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic                  cfg_hex_mode_i,
  input  logic                  push_i,
  input  logic                  full_i,
  input  logic [7:0]            rx_char_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  logic                  result_kind_i,
  input  logic [7:0]            echo_char_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output int unsigned           error_count_o,
  output int unsigned           result_count_o,
  output int unsigned           replies_due_o
);

  localparam int unsigned RADIX_HEX   = 16;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [4:0]  NOT_A_DIGIT = 5'd16;

  // One reply of the parser: an echoed character or a finished number.
  typedef struct packed {
    logic                  kind;
    logic [7:0]            ch;
    logic [VALUE_BITS-1:0] value;
  } reply_t;

  reply_t                predicted_replies[$];
  logic                  hex_mode;
  logic [VALUE_BITS-1:0] running_value;
  logic [COUNT_BITS-1:0] digits_entered;

  // Digit value of a character in the given mode, or NOT_A_DIGIT.
  function automatic logic [4:0] digit_value(input logic [7:0] c, input logic hex);
    logic [4:0] d;
    d = NOT_A_DIGIT;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      d = 5'(c - CHAR_0);
    end else if (hex && c >= CHAR_UA && c <= CHAR_UF) begin
      d = 5'(c - CHAR_UA) + {1'b0, HEX_LETTER_BASE};
    end else if (hex && c >= CHAR_LA && c <= CHAR_LF) begin
      d = 5'(c - CHAR_LA) + {1'b0, HEX_LETTER_BASE};
    end
    return d;
  endfunction

  // Advances the parser state by one character and queues the reply it causes.
  task automatic parse_rx_char(input logic [7:0] c);
    reply_t                r;
    logic [4:0]            d;
    logic [VALUE_BITS-1:0] radix;
    radix = hex_mode ? VALUE_BITS'(RADIX_HEX) : VALUE_BITS'(RADIX_DEC);
    d = digit_value(c, hex_mode);
    r = '0;
    if (c == CHAR_CR) begin
      r.kind = RES_VALUE;
      r.value = running_value;
      predicted_replies.push_back(r);
      running_value = '0;
      digits_entered = '0;
    end else if (d != NOT_A_DIGIT) begin
      running_value = running_value * radix + VALUE_BITS'(d);
      if (digits_entered != '1) begin
        digits_entered = digits_entered + 1'b1;
      end
      r.kind = RES_ECHO;
      r.ch = c;
      predicted_replies.push_back(r);
    end else if (c == CHAR_BS && digits_entered != '0) begin
      running_value = running_value / radix;
      digits_entered = digits_entered - 1'b1;
      r.kind = RES_ECHO;
      r.ch = c;
      predicted_replies.push_back(r);
    end
  endtask

  // Compares one result transfer with the oldest predicted reply.
  task automatic check_reply();
    reply_t want;
    if (predicted_replies.size() == 0) begin
      error_count_o++;
      if (error_count_o <= MAX_REPORTS) begin
        $display("unexpected result: kind %0d char %h value %h",
                 result_kind_i, echo_char_i, value_i);
      end
    end else begin
      want = predicted_replies.pop_front();
      result_count_o++;
      if (result_kind_i !== want.kind || echo_char_i !== want.ch ||
          value_i !== want.value) begin
        error_count_o++;
        if (error_count_o <= MAX_REPORTS) begin
          $display("result %0d: expected kind %0d char %h value %h,",
                   result_count_o, want.kind, want.ch, want.value);
          $display("  got kind %0d char %h value %h",
                   result_kind_i, echo_char_i, value_i);
        end
      end
    end
  endtask

  // Results are checked before this edge's input is parsed, oldest first.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_mode = 1'b0;
      running_value = '0;
      digits_entered = '0;
      predicted_replies.delete();
    end else begin
      if (pop_i && !empty_i) begin
        check_reply();
      end
      if (cfg_valid_i && cfg_ready_i) begin
        hex_mode = cfg_hex_mode_i;
      end
      if (push_i && !full_i) begin
        parse_rx_char(rx_char_i);
      end
    end
    replies_due_o = predicted_replies.size();
  end

endmodule

FILE: tb/tb.sv
module tb;
  import anp_pkg::*;

  localparam int unsigned HOLD_CYCLES       = 150;
  localparam int unsigned STALL_LIMIT       = 2000;
  localparam int unsigned SETTLE_CYCLES     = 16;
  localparam int unsigned ITEMS_PER_PHASE   = 360;
  localparam int unsigned LONG_ENTRY_DIGITS = 24;
  localparam int unsigned EXTRA_BACKSPACES  = 4;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic                      cfg_hex_mode;
  logic                      push;
  logic                      full;
  logic [7:0]                rx_char;
  logic                      empty;
  logic                      pop;
  logic                      result_kind;
  logic [7:0]                echo_char;
  logic [VALUE_BITS_DEF-1:0] value;

  int unsigned error_count;
  int unsigned result_count;
  int unsigned replies_due;
  int unsigned stall_cycles;
  int unsigned sent_count;
  int unsigned push_idle_pct;
  int unsigned pop_idle_pct;
  logic        cur_mode;
  logic        hold_req;
  logic        hold_done;

  ascii_number_entry_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_hex_mode_i (cfg_hex_mode),
    .push           (push),
    .full           (full),
    .rx_char_i      (rx_char),
    .empty          (empty),
    .pop            (pop),
    .result_kind_o  (result_kind),
    .echo_char_o    (echo_char),
    .value_o        (value)
  );

  number_entry_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_hex_mode_i (cfg_hex_mode),
    .push_i         (push),
    .full_i         (full),
    .rx_char_i      (rx_char),
    .empty_i        (empty),
    .pop_i          (pop),
    .result_kind_i  (result_kind),
    .echo_char_i    (echo_char),
    .value_i        (value),
    .error_count_o  (error_count),
    .result_count_o (result_count),
    .replies_due_o  (replies_due)
  );

  // Free-running clock with a period of 10.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random pop with one long hold-off on request.
  initial begin
    pop = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end
      pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  // Offers one character, with random idle cycles first, until its transfer.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    rx_char <= c;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    sent_count++;
  endtask

  // Writes the mode once the block has drained and settled.
  task automatic set_mode(input logic m);
    push <= 1'b0;
    while (replies_due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_hex_mode <= m;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    cur_mode = m;
  endtask

  // Random digit character that is valid in the given mode.
  function automatic logic [7:0] pick_digit(input logic hex);
    int unsigned n;
    n = hex ? $urandom_range(21) : $urandom_range(9);
    if (n < 10) begin
      return 8'(CHAR_0 + n);
    end else if (n < 16) begin
      return 8'(CHAR_UA + (n - 10));
    end
    return 8'(CHAR_LA + (n - 16));
  endfunction

  // Mostly complete number entries, with noise and broken entries mixed in.
  task automatic run_random(input int unsigned n, input int unsigned send_pct,
                            input int unsigned recv_pct);
    int unsigned counted;
    int unsigned len;
    int unsigned k;
    push_idle_pct = send_pct;
    pop_idle_pct = recv_pct;
    counted = 0;
    while (counted < n) begin
      if ($urandom_range(99) < 80) begin
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(99) < 4) begin
            set_mode(!cur_mode);
          end
          send_char(pick_digit(cur_mode));
          counted++;
          if ($urandom_range(99) < 15) begin
            send_char(CHAR_BS);
            counted++;
          end
        end
        send_char(CHAR_CR);
        counted++;
      end else begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
          send_char(8'($urandom_range(255)));
          counted++;
        end
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    rx_char = '0;
    cfg_valid = 1'b0;
    cfg_hex_mode = 1'b0;
    hold_req = 1'b0;
    push_idle_pct = 0;
    pop_idle_pct = 0;
    cur_mode = 1'b0;
    sent_count = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Decimal mode out of reset: empty entry, range edges, ignored bytes.
    send_char(CHAR_CR);
    send_char(CHAR_BS);
    send_char(CHAR_0);
    send_char(CHAR_9);
    send_char(CHAR_0 - 8'd1);
    send_char(CHAR_9 + 8'd1);
    send_char(CHAR_UA);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CHAR_BS);
    send_char(CHAR_0 + 8'd5);

    // Switch to hex in the middle of the entry; letters of both cases.
    set_mode(1'b1);
    send_char(CHAR_UA);
    send_char(CHAR_UF);
    send_char(CHAR_LA);
    send_char(CHAR_LF);
    send_char(CHAR_UF + 8'd1);
    send_char(CHAR_LF + 8'd1);
    send_char(CHAR_UA - 8'd1);
    send_char(CHAR_LA - 8'd1);
    send_char(CHAR_BS);
    send_char(CHAR_CR);
    set_mode(1'b0);

    // Random phases with different idle patterns.
    run_random(ITEMS_PER_PHASE, 18, 76);
    run_random(ITEMS_PER_PHASE, 76, 18);
    hold_req = 1'b1;
    run_random(ITEMS_PER_PHASE, 0, 0);

    // A long hex entry that wraps the value, then backspaces past its start.
    set_mode(1'b1);
    repeat (LONG_ENTRY_DIGITS) send_char(pick_digit(1'b1));
    repeat (LONG_ENTRY_DIGITS + EXTRA_BACKSPACES) send_char(CHAR_BS);
    send_char(CHAR_0 + 8'd1);
    send_char(CHAR_CR);

    push <= 1'b0;
    while (replies_due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Sent %0d characters in decimal and hex mode; %0d results checked.",
             sent_count, result_count);
    $display("Run included wraparound, backspace on empty entries and a long receiver hold-off.");
    if (error_count == 0 && replies_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
